/* hw/rtl/mwe_pkg.sv */
package mwe_pkg;

   localparam int ANGLE_TABLE_LEN = 24;
   localparam int ROTATION_STAGES_DEF = 16;
   localparam int SERIES_TERMS = 12;
   localparam int ENV_LATENCY = 4 + 2 * SERIES_TERMS;

   localparam logic [15:0] CENTER_FREQ_RESET = 16'd25736;
   localparam logic [31:0] PHASE_SCALE = 32'd2734261102;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [30:0] ONE_Q30 = 31'h40000000;
   localparam logic signed [63:0] OUT_MAX = 64'sd131071;
   localparam logic signed [63:0] OUT_MIN = -64'sd131072;

   typedef logic [31:0] atan_table_type [ANGLE_TABLE_LEN];
   localparam atan_table_type ATAN_Q30 = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   // reciprocal multipliers: floor(a / n) = (a * DIV_MUL[n]) >> DIV_SHIFT[n] for a < 2^30
   typedef logic [30:0] div_mul_type [SERIES_TERMS + 1];
   typedef int div_shift_type [SERIES_TERMS + 1];
   localparam div_mul_type DIV_MUL = '{
      31'd1073741824, 31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
      31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824, 31'd1908874354,
      31'd1717986919, 31'd1561806290, 31'd1431655766
   };
   localparam div_shift_type DIV_SHIFT = '{
      30, 30, 31, 32, 32, 33, 33, 33, 33, 34, 34, 34, 34
   };

   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] half;
      neg = v[63];
      mag = neg ? (64'd0 - v) : v;
      half = 64'd1 << (s - 1);
      mag = (mag + half) >> s;
      return neg ? $signed(64'd0 - mag) : $signed(mag);
   endfunction

   function automatic logic [17:0] sat18(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = v;
      if (c > OUT_MAX) c = OUT_MAX;
      if (c < OUT_MIN) c = OUT_MIN;
      return c[17:0];
   endfunction

endpackage

/* hw/rtl/mwe_rotation.sv */
module mwe_rotation #(
   parameter int ROTATION_STAGES = mwe_pkg::ROTATION_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] x,
   input  logic        [15:0] w0,
   output logic               out_valid,
   output logic signed [33:0] cos_q30,
   output logic signed [33:0] sin_q30
);

   localparam int NS = (ROTATION_STAGES > mwe_pkg::ANGLE_TABLE_LEN) ?
                       mwe_pkg::ANGLE_TABLE_LEN : ROTATION_STAGES;
   localparam int PAD = mwe_pkg::ENV_LATENCY - (4 + NS);

   logic signed [31:0] p_ff, p_in;
   logic               p_v_ff;
   logic        [31:0] ph_ff, ph_in;
   logic               ph_v_ff;

   logic signed [32:0] p_full;
   logic signed [64:0] ph_full;
   logic signed [30:0] r_in;
   logic        [1:0]  q_in;
   logic signed [63:0] zp;
   logic signed [63:0] zr;

   logic signed [33:0] cx [1:NS];
   logic signed [33:0] cy [1:NS];
   logic signed [31:0] cz [0:NS];
   logic        [1:0]  cq [0:NS];
   logic               cv [0:NS];

   logic signed [33:0] pc [0:PAD];
   logic signed [33:0] ps [0:PAD];
   logic               pv [0:PAD];

   assign p_full = x * $signed({1'b0, w0});
   assign p_in = p_full[31:0];
   assign ph_full = p_ff * $signed({1'b0, mwe_pkg::PHASE_SCALE});
   assign ph_in = ph_full[55:24];

   always_comb begin
      q_in = ph_ff[31:30];
      r_in = $signed({1'b0, ph_ff[29:0]});
      if (ph_ff[29]) begin
         r_in = r_in - 31'sh40000000;
         q_in = q_in + 2'd1;
      end
   end

   assign zp = r_in * $signed({1'b0, mwe_pkg::HALF_PI_Q30});
   assign zr = mwe_pkg::rnd_shift(zp, 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         ph_v_ff <= 1'b0;
         cv[0] <= 1'b0;
      end else if (en) begin
         p_v_ff <= in_valid;
         ph_v_ff <= p_v_ff;
         cv[0] <= ph_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
         ph_ff <= ph_in;
         cz[0] <= zr[31:0];
         cq[0] <= q_in;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic signed [33:0] xi, yi;
      logic signed [31:0] ang;
      if (k == 0) begin : g_first
         assign xi = mwe_pkg::CORDIC_GAIN_Q30;
         assign yi = '0;
      end else begin : g_next
         assign xi = cx[k];
         assign yi = cy[k];
      end
      assign ang = $signed(mwe_pkg::ATAN_Q30[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            cv[k+1] <= 1'b0;
         end else if (en) begin
            cv[k+1] <= cv[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!cz[k][31]) begin
               cx[k+1] <= xi - (yi >>> k);
               cy[k+1] <= yi + (xi >>> k);
               cz[k+1] <= cz[k] - ang;
            end else begin
               cx[k+1] <= xi + (yi >>> k);
               cy[k+1] <= yi - (xi >>> k);
               cz[k+1] <= cz[k] + ang;
            end
            cq[k+1] <= cq[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv[0] <= 1'b0;
      end else if (en) begin
         pv[0] <= cv[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         case (cq[NS])
            2'd0: begin
               pc[0] <= cx[NS];
               ps[0] <= cy[NS];
            end
            2'd1: begin
               pc[0] <= -cy[NS];
               ps[0] <= cx[NS];
            end
            2'd2: begin
               pc[0] <= -cx[NS];
               ps[0] <= -cy[NS];
            end
            default: begin
               pc[0] <= cy[NS];
               ps[0] <= -cx[NS];
            end
         endcase
      end
   end

   for (genvar d = 0; d < PAD; d++) begin : g_pad
      always_ff @(posedge clock) begin
         if (reset) begin
            pv[d+1] <= 1'b0;
         end else if (en) begin
            pv[d+1] <= pv[d];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            pc[d+1] <= pc[d];
            ps[d+1] <= ps[d];
         end
      end
   end

   assign out_valid = pv[PAD];
   assign cos_q30 = pc[PAD];
   assign sin_q30 = ps[PAD];

endmodule

/* hw/rtl/mwe_envelope.sv */
module mwe_envelope (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] x,
   output logic               out_valid,
   output logic signed [15:0] out_x,
   output logic        [30:0] env
);

   localparam int NT = mwe_pkg::SERIES_TERMS;

   typedef struct packed {
      logic signed [15:0] x;
      logic        [29:0] t;
      logic        [4:0]  k;
      logic               zero;
   } env_side_type;

   logic signed [15:0] x1_ff, x2_ff;
   logic        [30:0] sq_ff;
   logic        [40:0] v_ff;
   logic               v1_ff, v2_ff;
   logic signed [31:0] sq_full;
   logic        [61:0] v_full;
   logic        [59:0] t_full;
   logic        [10:0] k_full;

   logic        [30:0] term [0:NT];
   logic signed [32:0] sum  [0:NT];
   env_side_type       bs   [0:NT];
   logic               bv   [0:NT];
   logic        [29:0] am   [1:NT];
   logic signed [32:0] asum [1:NT];
   env_side_type       as_  [1:NT];
   logic               av   [1:NT];

   logic        [30:0] env_ff;
   logic signed [15:0] x_out_ff;
   logic               v_out_ff;
   logic signed [32:0] shifted;

   assign sq_full = x * x;
   assign v_full = sq_ff * mwe_pkg::LOG2E_Q30;
   assign k_full = v_ff[40:30];
   assign t_full = v_ff[29:0] * mwe_pkg::LN2_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         bv[0] <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         bv[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_full[30:0];
         x1_ff <= x;
         v_ff <= v_full[61:21];
         x2_ff <= x1_ff;
         term[0] <= mwe_pkg::ONE_Q30;
         sum[0] <= $signed({2'b00, mwe_pkg::ONE_Q30});
         bs[0].x <= x2_ff;
         bs[0].t <= t_full[59:30];
         bs[0].k <= k_full[4:0];
         bs[0].zero <= (k_full > 11'd30);
      end
   end

   for (genvar j = 1; j <= NT; j++) begin : g_term
      logic [60:0] m_full;
      logic [60:0] q_full;
      logic [29:0] q;
      assign m_full = term[j-1] * bs[j-1].t;
      assign q_full = (am[j] * mwe_pkg::DIV_MUL[j]) >> mwe_pkg::DIV_SHIFT[j];
      assign q = q_full[29:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            av[j] <= 1'b0;
            bv[j] <= 1'b0;
         end else if (en) begin
            av[j] <= bv[j-1];
            bv[j] <= av[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            am[j] <= m_full[59:30];
            asum[j] <= sum[j-1];
            as_[j] <= bs[j-1];
            term[j] <= {1'b0, q};
            if (j % 2 == 1) begin
               sum[j] <= asum[j] - $signed({3'b000, q});
            end else begin
               sum[j] <= asum[j] + $signed({3'b000, q});
            end
            bs[j] <= as_[j];
         end
      end
   end

   assign shifted = sum[NT] >>> bs[NT].k;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_out_ff <= 1'b0;
      end else if (en) begin
         v_out_ff <= bv[NT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         env_ff <= bs[NT].zero ? '0 : shifted[30:0];
         x_out_ff <= bs[NT].x;
      end
   end

   assign out_valid = v_out_ff;
   assign out_x = x_out_ff;
   assign env = env_ff;

endmodule

/* hw/rtl/morlet_wavelet_eval_top.sv */
// Morlet wavelet evaluator: psi(x) = exp(-x^2/2) * exp(i w0 x) and its derivative.
// Input channel req_: one position req_sample_pos (signed Q6.10) per transfer.
// Result channel rsp_: psi in rsp_wave_re/rsp_wave_im (signed Q2.16) and the
// derivative (-x + i w0) psi in rsp_deriv_re/rsp_deriv_im (signed Q6.12), all
// rounded and saturated to 18 bits. One result per input, in order.
// csr_: write csr_write_data into w0 (unsigned Q4.12) when csr_write_en is high;
// write only while no transfer is in flight. Reset value is about two pi.
// Each result passes through the envelope pipeline (3 setup stages, 12 Taylor
// terms of two stages each, a shift stage) and then 4 stages that form the
// products and round. The sine/cosine rotation runs alongside and is padded to
// the same depth.
// Throughput is one item per cycle. All stages advance together; when rsp_valid
// is high and rsp_stall is high the whole pipeline holds and req_stall is raised,
// so nothing is dropped or repeated.
// Synchronous reset clears all valid bits and restores w0.
module morlet_wavelet_eval_top #(
   parameter int ROTATION_STAGES = mwe_pkg::ROTATION_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_pos,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_wave_re,
   output logic signed [17:0] rsp_wave_im,
   output logic signed [17:0] rsp_deriv_re,
   output logic signed [17:0] rsp_deriv_im,
   input  logic               csr_write_en,
   input  logic        [15:0] csr_write_data
);

   logic        [15:0] w0_ff;
   logic               en;

   logic               rot_v, env_v, v0;
   logic signed [33:0] cos_q30, sin_q30;
   logic        [30:0] env;
   logic signed [15:0] env_x;

   logic signed [63:0] pc_ff, ps_ff;
   logic signed [15:0] x1_ff, x2_ff;
   logic               v1_ff, v2_ff, v3_ff;
   logic signed [33:0] ce_ff, se_ff, ce3_ff, se3_ff;
   logic signed [63:0] xc_ff, xs_ff, wc_ff, ws_ff;
   logic signed [63:0] ce_r, se_r;
   logic signed [17:0] x4;
   logic signed [63:0] dre, dim;

   logic               rsp_valid_ff;
   logic        [17:0] wre_ff, wim_ff, dre_ff, dim_ff;

   assign en = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff <= mwe_pkg::CENTER_FREQ_RESET;
      end else if (csr_write_en) begin
         w0_ff <= csr_write_data;
      end
   end

   mwe_rotation #(
      .ROTATION_STAGES(ROTATION_STAGES)
   ) u_rotation (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .x        (req_sample_pos),
      .w0       (w0_ff),
      .out_valid(rot_v),
      .cos_q30  (cos_q30),
      .sin_q30  (sin_q30)
   );

   mwe_envelope u_envelope (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .x        (req_sample_pos),
      .out_valid(env_v),
      .out_x    (env_x),
      .env      (env)
   );

   assign v0 = rot_v & env_v;
   assign ce_r = mwe_pkg::rnd_shift(pc_ff, 30);
   assign se_r = mwe_pkg::rnd_shift(ps_ff, 30);
   assign x4 = {x2_ff, 2'b00};
   assign dre = -xc_ff - ws_ff;
   assign dim = -xs_ff + wc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff <= $signed({1'b0, env}) * cos_q30;
         ps_ff <= $signed({1'b0, env}) * sin_q30;
         x1_ff <= env_x;
         ce_ff <= ce_r[33:0];
         se_ff <= se_r[33:0];
         x2_ff <= x1_ff;
         xc_ff <= x4 * ce_ff;
         xs_ff <= x4 * se_ff;
         wc_ff <= $signed({1'b0, w0_ff}) * ce_ff;
         ws_ff <= $signed({1'b0, w0_ff}) * se_ff;
         ce3_ff <= ce_ff;
         se3_ff <= se_ff;
         wre_ff <= mwe_pkg::sat18(mwe_pkg::rnd_shift(64'(ce3_ff), 14));
         wim_ff <= mwe_pkg::sat18(mwe_pkg::rnd_shift(64'(se3_ff), 14));
         dre_ff <= mwe_pkg::sat18(mwe_pkg::rnd_shift(dre, 30));
         dim_ff <= mwe_pkg::sat18(mwe_pkg::rnd_shift(dim, 30));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_wave_re = $signed(wre_ff);
   assign rsp_wave_im = $signed(wim_ff);
   assign rsp_deriv_re = $signed(dre_ff);
   assign rsp_deriv_im = $signed(dim_ff);

endmodule

/* hw/rtl/mwe_checker.sv */
module mwe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [17:0] rsp_wave_re,
   input logic [17:0] rsp_wave_im,
   input logic [17:0] rsp_deriv_re,
   input logic [17:0] rsp_deriv_im
);

   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow a held result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_wave_re) &&
         $stable(rsp_wave_im) && $stable(rsp_deriv_re) && $stable(rsp_deriv_im)))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind morlet_wavelet_eval_top mwe_checker u_mwe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_wave_re (rsp_wave_re),
   .rsp_wave_im (rsp_wave_im),
   .rsp_deriv_re(rsp_deriv_re),
   .rsp_deriv_im(rsp_deriv_im)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [17:0] wave_re;
      logic [17:0] wave_im;
      logic [17:0] deriv_re;
      logic [17:0] deriv_im;
   } wavelet_sample_type;

   localparam int CFG_CENTER_FREQ = 0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample_pos = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [17:0] rsp_wave_re;
   logic signed [17:0] rsp_wave_im;
   logic signed [17:0] rsp_deriv_re;
   logic signed [17:0] rsp_deriv_im;
   logic               csr_write_en = 1'b0;
   logic        [15:0] csr_write_data = '0;

   wavelet_sample_type pending_samples[$];
   logic [15:0]        model_freq = mwe_pkg::CENTER_FREQ_RESET;
   int                 error_count = 0;
   int                 sender_idle_pct = 0;
   int                 stall_pct = 0;

   morlet_wavelet_eval_top uut (.*);

   always #6 clock = ~clock;

   function automatic longint shift_round(longint v, int s);
      logic [63:0] mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [17:0] clamp18(longint v);
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v[17:0];
   endfunction

   function automatic longint gauss_q30(longint x);
      logic [63:0] u21, v30, k, t, term;
      longint      sum;
      u21 = x * x;
      v30 = (u21 * 64'd1549082005) >> 21;
      k = v30 >> 30;
      t = ((v30 & 64'h3FFF_FFFF) * 64'd744261118) >> 30;
      sum = 64'sd1073741824;
      term = 64'd1073741824;
      if (k > 30) return 0;
      for (int n = 1; n <= mwe_pkg::SERIES_TERMS; n++) begin
         term = ((term * t) >> 30) / n;
         if (n % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      return sum >>> k;
   endfunction

   function automatic wavelet_sample_type morlet_predict(logic signed [15:0] pos,
                                                         logic [15:0] w0);
      longint             x, w, p, r, z, px, py, nx, tmp, env, ce, se, dre, dim;
      logic [63:0]        prod;
      logic [31:0]        phase;
      logic [1:0]         quad;
      wavelet_sample_type res;
      x = pos;
      w = w0;
      p = x * w;
      prod = 64'(p) * 64'd2734261102;
      phase = prod[55:24];
      quad = phase[31:30];
      r = phase[29:0];
      if (r >= (64'sd1 << 29)) begin
         r -= 64'sd1073741824;
         quad = quad + 2'd1;
      end
      z = shift_round(r * 64'sd1686629713, 30);
      px = 64'sd652032874;
      py = 0;
      for (int i = 0; i < mwe_pkg::ROTATION_STAGES_DEF && i < mwe_pkg::ANGLE_TABLE_LEN;
           i++) begin
         if (z >= 0) begin
            nx = px - (py >>> i);
            py = py + (px >>> i);
            z -= longint'(mwe_pkg::ATAN_Q30[i]);
         end else begin
            nx = px + (py >>> i);
            py = py - (px >>> i);
            z += longint'(mwe_pkg::ATAN_Q30[i]);
         end
         px = nx;
      end
      case (quad)
         2'd0: ;
         2'd1: begin tmp = px; px = -py; py = tmp; end
         2'd2: begin px = -px; py = -py; end
         default: begin tmp = px; px = py; py = -tmp; end
      endcase
      env = gauss_q30(x);
      ce = shift_round(env * px, 30);
      se = shift_round(env * py, 30);
      dre = -(x * 4) * ce - w * se;
      dim = -(x * 4) * se + w * ce;
      res.wave_re = clamp18(shift_round(ce, 14));
      res.wave_im = clamp18(shift_round(se, 14));
      res.deriv_re = clamp18(shift_round(dre, 30));
      res.deriv_im = clamp18(shift_round(dim, 30));
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got), $signed(want),
               $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      wavelet_sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("unexpected result transfer at %0t", $realtime);
            error_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_wave_re !== want.wave_re)
               report_mismatch("wave_re", rsp_wave_re, want.wave_re);
            if (rsp_wave_im !== want.wave_im)
               report_mismatch("wave_im", rsp_wave_im, want.wave_im);
            if (rsp_deriv_re !== want.deriv_re)
               report_mismatch("deriv_re", rsp_deriv_re, want.deriv_re);
            if (rsp_deriv_im !== want.deriv_im)
               report_mismatch("deriv_im", rsp_deriv_im, want.deriv_im);
         end
      end
   end

   task automatic send_position(logic signed [15:0] pos);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_pos <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_samples.push_back(morlet_predict(pos, model_freq));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_center_freq(logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      model_freq = value;
   endtask

   function automatic logic signed [15:0] pick_position();
      if ($urandom_range(0, 99) < 70) return 16'($signed($urandom_range(0, 14000)) - 7000);
      return 16'($urandom);
   endfunction

   task automatic test_extremes();
      logic signed [15:0] edge_pos[$] = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
                                          16'sd1024, -16'sd1024, 16'sd6500, -16'sd6500,
                                          16'sd7000, -16'sd7000, 16'sd256, 16'h5555,
                                          16'h2AAA};
      foreach (edge_pos[i]) send_position(edge_pos[i]);
      drain_pipeline();
   endtask

   task automatic test_frequency_extremes();
      logic [15:0] freqs[$] = '{16'd0, 16'hFFFF, 16'd1, 16'h8000};
      foreach (freqs[f]) begin
         write_center_freq(freqs[f]);
         send_position(16'sd0);
         send_position(16'sd32767);
         send_position(-16'sd32768);
         send_position(16'sd700);
         send_position(-16'sd3000);
         drain_pipeline();
      end
   endtask

   task automatic test_random_phase(int idle_pct, int hold_pct, logic [15:0] freq, int count);
      sender_idle_pct = idle_pct;
      stall_pct = hold_pct;
      write_center_freq(freq);
      repeat (count) send_position(pick_position());
      drain_pipeline();
      sender_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_frequency_extremes();
      test_random_phase(0, 0, mwe_pkg::CENTER_FREQ_RESET, 225);
      test_random_phase(79, 0, 16'($urandom), 225);
      test_random_phase(0, 79, 16'hFFFF, 225);
      test_random_phase(37, 37, 16'($urandom), 225);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/mwe_pkg.sv
hw/rtl/mwe_rotation.sv
hw/rtl/mwe_envelope.sv
hw/rtl/morlet_wavelet_eval_top.sv
hw/rtl/mwe_checker.sv
verif/testbench.sv
